// ===== rtl/tle_pkg.sv =====
// Package for the terminal line editor: character codes, result kinds,
// data-select codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package tle_pkg;

    localparam int TLE_LINE_CAPACITY = 8;

    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SUB = 8'h1A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_UC_C  = 8'h43;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    localparam logic [1:0] DSEL_CONST = 2'd0;
    localparam logic [1:0] DSEL_CHAR  = 2'd1;
    localparam logic [1:0] DSEL_LINE  = 2'd2;

    typedef struct packed {
        logic       fill_dec;
        logic       fill_clr;
        logic       store_wr;
        logic       start_line;
        logic       char_ld;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
        logic [1:0] out_dsel;
        logic [7:0] out_byte;
        logic       rd_adv;
    } tle_cmd_t;

    typedef struct packed {
        logic is_sub;
        logic is_erase;
        logic is_etx;
        logic is_cr;
        logic is_print;
        logic empty;
        logic full;
        logic line_left;
        logic out_free;
    } tle_status_t;

endpackage

`default_nettype wire

// ===== rtl/tle_datapath.sv =====
// Datapath of the terminal line editor: line store, fill count, read pointer
// for line delivery and the result output register.
// Depends on tle_pkg.
`default_nettype none

module tle_datapath #(
    parameter int LINE_CAPACITY = tle_pkg::TLE_LINE_CAPACITY
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        rx_char,
    input  wire tle_pkg::tle_cmd_t cmd,
    output tle_pkg::tle_status_t   status,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [1:0]             kind,
    output logic [7:0]             data,
    output logic                   last
);
    import tle_pkg::*;

    localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

    logic [6:0]       store [LINE_CAPACITY];
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [6:0]       rd_reg;
    logic [7:0]       char_reg;
    logic             valid_reg, valid_next;
    logic [1:0]       kind_reg;
    logic [7:0]       data_reg, data_next;
    logic             last_reg;

    always_comb
    begin
        status.is_sub    = (rx_char == CH_SUB);
        status.is_erase  = (rx_char == CH_BS) || (rx_char == CH_DEL);
        status.is_etx    = (rx_char == CH_ETX);
        status.is_cr     = (rx_char == CH_CR);
        status.is_print  = (rx_char >= CH_SP) && (rx_char < CH_DEL);
        status.empty     = (fill_reg == '0);
        status.full      = (fill_reg == CAP);
        status.line_left = (rd_ptr_reg != len_reg);
        status.out_free  = !valid_reg || out_ready;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.fill_clr || cmd.start_line)
        begin
            fill_next = '0;
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - 1'b1;
        end
        else if (cmd.store_wr)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.start_line)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.rd_adv)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.out_dsel)
            DSEL_CHAR: data_next = char_reg;
            DSEL_LINE: data_next = {1'b0, rd_reg};
            default:   data_next = cmd.out_byte;
        endcase
        valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rd_ptr_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            rd_ptr_reg <= rd_ptr_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            store[fill_reg[ADDR_W-1:0]] <= rx_char[6:0];
        end
        if (rd_ptr_next < CAP)
        begin
            rd_reg <= store[rd_ptr_next[ADDR_W-1:0]];
        end
        if (cmd.start_line)
        begin
            len_reg <= fill_reg;
        end
        if (cmd.char_ld)
        begin
            char_reg <= rx_char;
        end
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            data_reg <= data_next;
            last_reg <= cmd.out_last;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP)
        else $error("fill count above capacity");

    a_line_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_dsel == DSEL_LINE) |-> (status.line_left && cmd.rd_adv))
        else $error("line byte loaded past the latched length");

    a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> (!status.full && !cmd.fill_clr && !cmd.start_line))
        else $error("store write on a full line");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten while held");

endmodule

`default_nettype wire

// ===== rtl/tle_ctrl.sv =====
// Controller of the terminal line editor: decodes the accepted item and
// sequences its results into the datapath output register, one per cycle while it is free.
// Depends on tle_pkg.
`default_nettype none

module tle_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tle_pkg::tle_status_t status,
    output tle_pkg::tle_cmd_t         cmd
);
    import tle_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam logic [2:0] SEQ_EOF  = 3'd0;
    localparam logic [2:0] SEQ_BS   = 3'd1;
    localparam logic [2:0] SEQ_ETX  = 3'd2;
    localparam logic [2:0] SEQ_CR   = 3'd3;
    localparam logic [2:0] SEQ_ECHO = 3'd4;
    localparam logic [2:0] SEQ_BEL  = 3'd5;

    logic       state_reg, state_next;
    logic [2:0] seq_reg, seq_next;
    logic [1:0] step_reg, step_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        seq_next   = seq_reg;
        step_next  = step_reg;
        cmd.char_ld = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                    if (status.is_sub && status.empty)
                    begin
                        seq_next = SEQ_EOF;
                    end
                    else if (status.is_erase)
                    begin
                        seq_next = SEQ_BS;
                        if (status.empty)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.fill_dec = 1'b1;
                        end
                    end
                    else if (status.is_etx)
                    begin
                        seq_next     = SEQ_ETX;
                        cmd.fill_clr = 1'b1;
                    end
                    else if (status.is_cr)
                    begin
                        seq_next       = SEQ_CR;
                        cmd.start_line = 1'b1;
                    end
                    else if (!status.full)
                    begin
                        seq_next = SEQ_ECHO;
                        if (status.is_print)
                        begin
                            cmd.store_wr = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        seq_next = SEQ_BEL;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_ECHO;
                    cmd.out_dsel = DSEL_CONST;
                    step_next    = step_reg + 1'b1;
                    unique case (seq_reg)
                        SEQ_EOF:
                        begin
                            unique case (step_reg)
                                2'd0:    cmd.out_byte = CH_CARET;
                                2'd1:    cmd.out_byte = CH_UC_Z;
                                default:
                                begin
                                    cmd.out_byte = CH_NUL;
                                    cmd.out_kind = KIND_EOF;
                                    cmd.out_last = 1'b1;
                                end
                            endcase
                        end
                        SEQ_BS:
                        begin
                            cmd.out_byte = (step_reg == 2'd1) ? CH_SP : CH_BS;
                            cmd.out_last = (step_reg == 2'd2);
                        end
                        SEQ_ETX:
                        begin
                            unique case (step_reg)
                                2'd0:    cmd.out_byte = CH_CARET;
                                2'd1:    cmd.out_byte = CH_UC_C;
                                2'd2:    cmd.out_byte = CH_CR;
                                default:
                                begin
                                    cmd.out_byte = CH_LF;
                                    cmd.out_last = 1'b1;
                                end
                            endcase
                        end
                        SEQ_CR:
                        begin
                            unique case (step_reg)
                                2'd0:    cmd.out_byte = CH_CR;
                                2'd1:    cmd.out_byte = CH_LF;
                                default:
                                begin
                                    cmd.out_kind = KIND_LINE;
                                    step_next    = step_reg;
                                    if (status.line_left)
                                    begin
                                        cmd.out_dsel = DSEL_LINE;
                                        cmd.rd_adv   = 1'b1;
                                    end
                                    else
                                    begin
                                        cmd.out_byte = CH_LF;
                                        cmd.out_last = 1'b1;
                                    end
                                end
                            endcase
                        end
                        SEQ_ECHO:
                        begin
                            cmd.out_dsel = DSEL_CHAR;
                            cmd.out_last = 1'b1;
                        end
                        default:
                        begin
                            cmd.out_byte = CH_BEL;
                            cmd.out_last = 1'b1;
                        end
                    endcase
                    if (cmd.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= SEQ_EOF;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            step_reg  <= step_next;
        end
    end

    a_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == ST_EMIT))
        else $error("result loaded outside a sequence");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> in_ready)
        else $error("sequence did not end after its final result");

    a_edit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill_dec || cmd.fill_clr || cmd.store_wr || cmd.start_line) |-> accept)
        else $error("line edited without an accepted item");

endmodule

`default_nettype wire

// ===== rtl/terminal_line_editor.sv =====
// Terminal line editor top level: controller plus datapath.
// Depends on tle_pkg, tle_ctrl and tle_datapath.
//
// Takes one received terminal byte per item and returns its results (echo
// bytes, delivered line bytes, end-of-file marker) one per cycle, while the
// output is not stalled, through a single output register, with last set on
// the final result of each item. An item occupies the block from its
// acceptance until its final result is loaded; an ignored byte produces no
// result, and a carriage return produces CR, LF, the line bytes and a final
// LF. Stalls on the output hold the sequence. The next item is taken as soon
// as the previous one's final result sits in the output register.
`default_nettype none

module terminal_line_editor #(
    parameter int LINE_CAPACITY = tle_pkg::TLE_LINE_CAPACITY
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_char,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      data,
    output logic            last
);
    import tle_pkg::*;

    tle_cmd_t    cmd;
    tle_status_t status;

    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tle_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_char   (rx_char),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

endmodule

`default_nettype wire
